### src/pbcg_pkg.sv
// Package for the pair budget credit gate: field widths, sizes and item codes.
package pbcg_pkg;

   // Sizing of the pair stores.
   localparam int NUM_DEVICES = 8;
   localparam int BUDGET_BITS = 32;
   localparam int PAIR_COUNT  = NUM_DEVICES * NUM_DEVICES;
   localparam int PAIR_BITS   = $clog2(PAIR_COUNT);

   // Fixed field widths of the channels and registers.
   localparam int KIND_BITS   = 2;
   localparam int DEV_BITS    = 3;
   localparam int AMOUNT_BITS = 32;
   localparam int STEP_BITS   = 32;
   localparam int CFG_BITS    = 16;
   localparam int CSR_IDX_BITS = 1;

   // Period is the sum of two register values, so it needs one more bit.
   localparam int PERIOD_BITS = CFG_BITS + 1;

   // Width that holds both a budget and a byte amount without loss.
   localparam int WIDE_BITS = (BUDGET_BITS > AMOUNT_BITS) ? BUDGET_BITS : AMOUNT_BITS;

   // One counter serves the remainder loop and the restore sweep.
   localparam int STEP_CNT_BITS = $clog2(STEP_BITS);
   localparam int CNT_BITS = (STEP_CNT_BITS > PAIR_BITS + 1) ? STEP_CNT_BITS : PAIR_BITS + 1;

   // Item kinds.
   localparam logic [KIND_BITS-1:0] KIND_ALLOC   = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_RESTORE = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_PACKET  = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_INTERVAL = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DELAY    = 1'd1;

   // Reset values of the registers.
   localparam logic [CFG_BITS-1:0] INTERVAL_RESET = 16'd1;
   localparam logic [CFG_BITS-1:0] DELAY_RESET    = 16'd0;

endpackage

### src/pair_budget_credit_gate.sv
// Top level of the pair budget credit gate: sequencer, pair stores and remainder unit.
//
// The block keeps an allocation and a byte budget for each source/destination
// device pair. Items arrive on the req_ channel, one result beat per item leaves
// on the rsp_ channel. An allocation item adds bytes to one pair's allocation,
// a restore item copies every present allocation into its budget, and a packet
// item is granted and deducted when it falls outside the reconfiguration window
// and the pair's budget covers it.
// One item at a time: req_stall is high from the accepting edge until the
// sequencer is idle again, which happens in the same cycle that rsp_valid
// rises. After acceptance an allocation or an unused kind goes through ST_EXEC
// and ST_OUT. A packet first runs ST_DIV, the bit-serial remainder unit that
// computes step_now modulo the period one step bit per cycle (skipped when the
// period is zero). A restore first runs ST_SWEEP, which walks the single read
// port of the allocation memory one pair per cycle, and then ST_READ.
// A finished result sits in the output register; while the receiver holds
// rsp_stall high the beat stays unchanged, and a following item may already be
// accepted and worked on, waiting only to load its own result.
// Synchronous reset clears both presence vectors, so every pair reads as empty
// at once, and restores the register defaults. The user writes the registers
// through the csr_ port only while the block is idle; the block does not check.
module pair_budget_credit_gate (
   input  logic                               clock,
   input  logic                               reset,
   // Configuration write port.
   input  logic                               csr_wr_en,
   input  logic [pbcg_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [pbcg_pkg::CFG_BITS-1:0]      csr_wdata,
   // Request channel.
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [pbcg_pkg::KIND_BITS-1:0]     req_kind,
   input  logic [pbcg_pkg::DEV_BITS-1:0]      req_src_device,
   input  logic [pbcg_pkg::DEV_BITS-1:0]      req_dst_device,
   input  logic [pbcg_pkg::AMOUNT_BITS-1:0]   req_byte_amount,
   input  logic [pbcg_pkg::STEP_BITS-1:0]     req_step_now,
   // Response channel.
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_granted,
   output logic                               rsp_in_reconfig,
   output logic [pbcg_pkg::AMOUNT_BITS-1:0]   rsp_budget_left
);
   import pbcg_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SWEEP,
      ST_READ,
      ST_EXEC,
      ST_OUT
   } state_type;

   // Sequencer and item registers.
   state_type                state_ff, state_in;
   logic [KIND_BITS-1:0]     kind_ff, kind_in;
   logic [PAIR_BITS-1:0]     idx_ff, idx_in;
   logic                     pair_ok_ff, pair_ok_in;
   logic [AMOUNT_BITS-1:0]   amount_ff, amount_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;
   logic [PERIOD_BITS-1:0]   rem_ff, rem_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;

   // Presence vectors act as valid bits of the two memories.
   logic [PAIR_COUNT-1:0]    apres_ff, apres_in;
   logic [PAIR_COUNT-1:0]    bpres_ff, bpres_in;

   // Result waiting for the output register.
   logic                     res_granted_ff, res_granted_in;
   logic                     res_reconf_ff, res_reconf_in;
   logic [AMOUNT_BITS-1:0]   res_left_ff, res_left_in;

   // Output register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_granted_ff, rsp_granted_in;
   logic                     rsp_reconf_ff, rsp_reconf_in;
   logic [AMOUNT_BITS-1:0]   rsp_left_ff, rsp_left_in;

   // Configuration registers.
   logic [CFG_BITS-1:0]      interval_ff, interval_in;
   logic [CFG_BITS-1:0]      delay_ff, delay_in;

   // Pair memories with registered read data.
   logic [BUDGET_BITS-1:0]   alloc_mem [PAIR_COUNT];
   logic [BUDGET_BITS-1:0]   budget_mem [PAIR_COUNT];
   logic [BUDGET_BITS-1:0]   alloc_q;
   logic [BUDGET_BITS-1:0]   budget_q;
   logic [PAIR_BITS-1:0]     alloc_raddr;
   logic [PAIR_BITS-1:0]     budget_raddr;
   logic                     alloc_we;
   logic [BUDGET_BITS-1:0]   alloc_wdata;
   logic                     budget_we;
   logic [PAIR_BITS-1:0]     budget_waddr;
   logic [BUDGET_BITS-1:0]   budget_wdata;

   // Helper signals.
   logic                     req_accept;
   logic [PAIR_BITS-1:0]     req_idx;
   logic                     req_ok;
   logic [PERIOD_BITS-1:0]   period;
   logic                     period_zero;
   logic [PERIOD_BITS:0]     rem_shift;
   logic                     blackout;
   logic                     budget_ok;
   logic [WIDE_BITS:0]       alloc_sum;
   logic [WIDE_BITS:0]       alloc_max;
   logic [BUDGET_BITS-1:0]   alloc_old;
   logic                     covers;
   logic [BUDGET_BITS-1:0]   budget_after;
   logic [WIDE_BITS-1:0]     left_wide;
   logic                     out_free;
   logic [PAIR_BITS-1:0]     sweep_waddr;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Pair index; an index outside the device range makes the pair absent.
   assign req_ok  = (int'(req_src_device) < NUM_DEVICES) && (int'(req_dst_device) < NUM_DEVICES);
   assign req_idx = req_ok ?
      PAIR_BITS'(int'(req_src_device) * NUM_DEVICES + int'(req_dst_device)) : '0;

   assign period      = PERIOD_BITS'(interval_ff) + PERIOD_BITS'(delay_ff);
   assign period_zero = (period == '0);

   // One step of the restoring remainder: bring in the next step bit and
   // subtract the period when the partial remainder reaches it.
   assign rem_shift = {rem_ff, step_ff[STEP_BITS-1]};

   assign blackout  = !period_zero && (rem_ff < PERIOD_BITS'(delay_ff));
   assign budget_ok = pair_ok_ff && bpres_ff[idx_ff];

   // An allocation that was never written counts as zero; the sum saturates.
   assign alloc_old = apres_ff[idx_ff] ? alloc_q : '0;
   assign alloc_sum = (WIDE_BITS+1)'(alloc_old) + (WIDE_BITS+1)'(amount_ff);
   assign alloc_max = (WIDE_BITS+1)'({BUDGET_BITS{1'b1}});

   assign covers       = WIDE_BITS'(budget_q) >= WIDE_BITS'(amount_ff);
   assign budget_after = budget_q - BUDGET_BITS'(amount_ff);

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign sweep_waddr = PAIR_BITS'(cnt_ff - CNT_BITS'(1));

   // Read addresses follow the request while idle, then the held item; the
   // allocation read address follows the sweep counter while restoring.
   assign alloc_raddr  = (state_ff == ST_IDLE)  ? req_idx :
                         (state_ff == ST_SWEEP) ? cnt_ff[PAIR_BITS-1:0] : idx_ff;
   assign budget_raddr = (state_ff == ST_IDLE)  ? req_idx : idx_ff;

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      idx_in         = idx_ff;
      pair_ok_in     = pair_ok_ff;
      amount_in      = amount_ff;
      step_in        = step_ff;
      rem_in         = rem_ff;
      cnt_in         = cnt_ff;
      apres_in       = apres_ff;
      bpres_in       = bpres_ff;
      res_granted_in = res_granted_ff;
      res_reconf_in  = res_reconf_ff;
      res_left_in    = res_left_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_reconf_in  = rsp_reconf_ff;
      rsp_left_in    = rsp_left_ff;
      interval_in    = interval_ff;
      delay_in       = delay_ff;
      alloc_we       = 1'b0;
      alloc_wdata    = alloc_q;
      budget_we      = 1'b0;
      budget_waddr   = idx_ff;
      budget_wdata   = budget_after;
      left_wide      = WIDE_BITS'(budget_q);

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_INTERVAL: interval_in = csr_wdata;
            CSR_DELAY:    delay_in    = csr_wdata;
            default:      ;
         endcase
      end

      // The beat leaves when the receiver takes it.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               kind_in    = req_kind;
               idx_in     = req_idx;
               pair_ok_in = req_ok;
               amount_in  = req_byte_amount;
               step_in    = req_step_now;
               rem_in     = '0;
               cnt_in     = '0;
               if (req_kind == KIND_RESTORE) begin
                  state_in = ST_SWEEP;
               end else if (req_kind == KIND_PACKET && !period_zero) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_DIV: begin
            if (rem_shift >= (PERIOD_BITS+1)'(period)) begin
               rem_in = PERIOD_BITS'(rem_shift - (PERIOD_BITS+1)'(period));
            end else begin
               rem_in = PERIOD_BITS'(rem_shift);
            end
            step_in = step_ff << 1;
            cnt_in  = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(STEP_BITS - 1)) begin
               state_in = ST_EXEC;
            end
         end
         ST_SWEEP: begin
            // Read of entry cnt is issued now; entry cnt-1 has its data.
            if (cnt_ff != '0 && apres_ff[sweep_waddr]) begin
               budget_we              = 1'b1;
               budget_waddr           = sweep_waddr;
               budget_wdata           = alloc_q;
               bpres_in[sweep_waddr]  = 1'b1;
            end
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(PAIR_COUNT)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            res_granted_in = 1'b0;
            res_reconf_in  = 1'b0;
            case (kind_ff)
               KIND_ALLOC: begin
                  if (pair_ok_ff) begin
                     alloc_we         = 1'b1;
                     alloc_wdata      = (alloc_sum > alloc_max) ?
                                        BUDGET_BITS'(alloc_max) : BUDGET_BITS'(alloc_sum);
                     apres_in[idx_ff] = 1'b1;
                  end
               end
               KIND_PACKET: begin
                  if (blackout) begin
                     res_reconf_in = 1'b1;
                  end else if (budget_ok && covers) begin
                     budget_we      = 1'b1;
                     res_granted_in = 1'b1;
                     left_wide      = WIDE_BITS'(budget_after);
                  end
               end
               default: ;
            endcase
            res_left_in = budget_ok ? left_wide[AMOUNT_BITS-1:0] : '0;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_reconf_in  = res_reconf_ff;
               rsp_left_in    = res_left_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         apres_ff     <= '0;
         bpres_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         interval_ff  <= INTERVAL_RESET;
         delay_ff     <= DELAY_RESET;
      end else begin
         state_ff     <= state_in;
         apres_ff     <= apres_in;
         bpres_ff     <= bpres_in;
         rsp_valid_ff <= rsp_valid_in;
         interval_ff  <= interval_in;
         delay_ff     <= delay_in;
      end
      kind_ff        <= kind_in;
      idx_ff         <= idx_in;
      pair_ok_ff     <= pair_ok_in;
      amount_ff      <= amount_in;
      step_ff        <= step_in;
      rem_ff         <= rem_in;
      cnt_ff         <= cnt_in;
      res_granted_ff <= res_granted_in;
      res_reconf_ff  <= res_reconf_in;
      res_left_ff    <= res_left_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_reconf_ff  <= rsp_reconf_in;
      rsp_left_ff    <= rsp_left_in;
   end

   // Allocation memory: one write, one registered read.
   always_ff @(posedge clock) begin
      if (alloc_we) begin
         alloc_mem[idx_ff] <= alloc_wdata;
      end
      alloc_q <= alloc_mem[alloc_raddr];
   end

   // Budget memory: one write, one registered read.
   always_ff @(posedge clock) begin
      if (budget_we) begin
         budget_mem[budget_waddr] <= budget_wdata;
      end
      budget_q <= budget_mem[budget_raddr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_granted     = rsp_granted_ff;
   assign rsp_in_reconfig = rsp_reconf_ff;
   assign rsp_budget_left = rsp_left_ff;

endmodule
